// ===== rtl/core/assert_macros.svh =====
// assertion macros for the unique key stack rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent in any cycle implies consequent in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/uks_pkg.sv =====
// types and constants of the unique key stack
package uks_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int KEY_W     = 32;
  localparam int DATA_W    = 32;
  localparam int CNT_OUT_W = 5;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_PEEK  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  // what every cell does on a clock edge
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,
    OP_POP,
    OP_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/uks_cell.sv =====
// one stack cell: holds a key and data pair, shifts with its neighbours
module uks_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                                clk,
  input  uks_pkg::cell_ctrl_t                 ctrl,
  input  logic [CW-1:0]                       fill,
  input  logic signed [uks_pkg::KEY_W-1:0]    prev_key,
  input  logic signed [uks_pkg::DATA_W-1:0]   prev_data,
  input  logic signed [uks_pkg::KEY_W-1:0]    next_key,
  input  logic signed [uks_pkg::DATA_W-1:0]   next_data,
  input  logic signed [uks_pkg::KEY_W-1:0]    wrap_key,
  input  logic signed [uks_pkg::DATA_W-1:0]   wrap_data,
  output logic signed [uks_pkg::KEY_W-1:0]    key,
  output logic signed [uks_pkg::DATA_W-1:0]   data
);
  import uks_pkg::*;

  logic signed [KEY_W-1:0]  key_r,  key_nxt;
  logic signed [DATA_W-1:0] data_r, data_nxt;
  logic                     is_last;

  assign is_last = (fill == CW'(IDX + 1));

  always_comb begin
    key_nxt  = key_r;
    data_nxt = data_r;
    case (ctrl.op)
      OP_PUSH: begin
        key_nxt  = prev_key;
        data_nxt = prev_data;
      end
      OP_POP: begin
        key_nxt  = next_key;
        data_nxt = next_data;
      end
      OP_ROTATE: begin
        if (is_last) begin
          key_nxt  = wrap_key;
          data_nxt = wrap_data;
        end else begin
          key_nxt  = next_key;
          data_nxt = next_data;
        end
      end
      default: begin
        key_nxt  = key_r;
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    data_r <= data_nxt;
  end

  assign key  = key_r;
  assign data = data_r;

endmodule

// ===== rtl/core/uks_ctrl.sv =====
// sequencer: request handshake, duplicate scan, fill count and result register
`include "assert_macros.svh"

module uks_ctrl #(
  parameter int DEPTH = uks_pkg::DEPTH_DEF,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  uks_pkg::cmd_t                       in_cmd,
  input  logic signed [uks_pkg::KEY_W-1:0]    in_key,
  input  logic signed [uks_pkg::DATA_W-1:0]   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output uks_pkg::status_t                    out_status,
  output logic signed [uks_pkg::KEY_W-1:0]    out_key,
  output logic signed [uks_pkg::DATA_W-1:0]   out_data,
  output logic [uks_pkg::CNT_OUT_W-1:0]       out_count,
  output logic                                out_empty,
  input  logic signed [uks_pkg::KEY_W-1:0]    top_key,
  input  logic signed [uks_pkg::DATA_W-1:0]   top_data,
  output uks_pkg::cell_ctrl_t                 cell_ctrl,
  output logic [CW-1:0]                       fill,
  output logic signed [uks_pkg::KEY_W-1:0]    push_key,
  output logic signed [uks_pkg::DATA_W-1:0]   push_data
);
  import uks_pkg::*;

  state_t                   state_r, state_nxt;
  cmd_t                     cmd_r;
  logic signed [KEY_W-1:0]  key_r;
  logic signed [DATA_W-1:0] data_r;
  logic [CW-1:0]            fill_r, fill_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic                     hit_r, hit_nxt;
  logic                     in_acc, out_go, scan_end;

  logic                     out_valid_r, out_valid_nxt;
  status_t                  status_r, status_nxt;
  logic signed [KEY_W-1:0]  okey_r, okey_nxt;
  logic signed [DATA_W-1:0] odata_r, odata_nxt;
  logic [CNT_OUT_W-1:0]     ocnt_r;
  logic                     oempty_r;
  cell_op_t                 op;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_go   = !out_valid_r || out_ready;
  assign scan_end = (cnt_r == fill_r - CW'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_PUSH && fill_r != '0) state_nxt = S_SCAN;
          else state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        if (scan_end) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_go) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath controls and result
  always_comb begin
    op            = OP_HOLD;
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    okey_nxt      = okey_r;
    odata_nxt     = odata_r;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        hit_nxt = 1'b0;
      end
      S_SCAN: begin
        op      = OP_ROTATE;
        hit_nxt = hit_r || (top_key == key_r);
        cnt_nxt = cnt_r + CW'(1);
      end
      S_DONE: begin
        if (out_go) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_OK;
          okey_nxt      = '0;
          odata_nxt     = '0;
          case (cmd_r)
            CMD_PUSH: begin
              if (hit_r) status_nxt = ST_DUP;
              else if (fill_r == CW'(DEPTH)) status_nxt = ST_FULL;
              else begin
                op       = OP_PUSH;
                fill_nxt = fill_r + CW'(1);
              end
            end
            CMD_POP, CMD_PEEK: begin
              if (fill_r == '0) status_nxt = ST_EMPTY;
              else begin
                okey_nxt  = top_key;
                odata_nxt = top_data;
                if (cmd_r == CMD_POP) begin
                  op       = OP_POP;
                  fill_nxt = fill_r - CW'(1);
                end
              end
            end
            default: status_nxt = ST_OK;
          endcase
        end
      end
      default: op = OP_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    hit_r    <= hit_nxt;
    status_r <= status_nxt;
    okey_r   <= okey_nxt;
    odata_r  <= odata_nxt;
    if (state_r == S_DONE && out_go) begin
      ocnt_r   <= CNT_OUT_W'(fill_nxt);
      oempty_r <= (fill_nxt == '0);
    end
    if (in_acc) begin
      cmd_r  <= in_cmd;
      key_r  <= in_key;
      data_r <= in_data;
    end
  end

  assign cell_ctrl.op = op;
  assign fill         = fill_r;
  assign push_key     = key_r;
  assign push_data    = data_r;
  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_key      = okey_r;
  assign out_data     = odata_r;
  assign out_count    = ocnt_r;
  assign out_empty    = oempty_r;

  `ASSERT_ALWAYS(a_fill_max, fill_r <= CW'(DEPTH), "fill level above depth")
  `ASSERT_ALWAYS(a_scan_nonempty, state_r != S_SCAN || fill_r != '0, "scan on empty stack")
  `ASSERT_NEXT(a_push_scan, in_acc && in_cmd == CMD_PUSH && fill_r != '0, state_r == S_SCAN, "push skipped scan")
  `ASSERT_NEXT(a_done_result, state_r == S_DONE && out_go, out_valid_r && state_r == S_IDLE, "result not registered")

endmodule

// ===== rtl/core/unique_key_stack_core.sv =====
// top level of the unique key stack: sequencer and a row of stack cells
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready   | tuser cmd, tdata key and data
//  out_    | out | out_tvalid/out_tready | tuser status, tdata key, data, count, empty
//
// pop, peek and the unused command go from idle straight to the finishing step, which registers the result
// a push on a non-empty stack first scans: the occupied cells rotate once around, one key compare
// a cycle at the top cell, so the stack is back in order when the scan ends
// reset clears the fill level and the handshake state; cell contents stay undefined
// a result that is still held stalls the next finishing step, and no new request is taken meanwhile
module unique_key_stack_core #(
  parameter int DEPTH = uks_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // cmd
  input  logic [63:0] in_tdata,   // in_key, in_data
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // status
  output logic [71:0] out_tdata   // out_key, out_data, entry_count, is_empty, zero pad
);
  import uks_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  cell_ctrl_t               cell_ctrl;
  logic [CW-1:0]            fill;
  logic signed [KEY_W-1:0]  push_key;
  logic signed [DATA_W-1:0] push_data;
  status_t                  out_status;
  logic signed [KEY_W-1:0]  out_key;
  logic signed [DATA_W-1:0] out_data;
  logic [CNT_OUT_W-1:0]     out_count;
  logic                     out_empty;

  logic signed [KEY_W-1:0]  cell_key  [DEPTH];
  logic signed [DATA_W-1:0] cell_data [DEPTH];

  uks_ctrl #(.DEPTH(DEPTH), .CW(CW)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_cmd     (cmd_t'(in_tuser)),
    .in_key     (in_tdata[31:0]),
    .in_data    (in_tdata[63:32]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_status),
    .out_key    (out_key),
    .out_data   (out_data),
    .out_count  (out_count),
    .out_empty  (out_empty),
    .top_key    (cell_key[0]),
    .top_data   (cell_data[0]),
    .cell_ctrl  (cell_ctrl),
    .fill       (fill),
    .push_key   (push_key),
    .push_data  (push_data)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [KEY_W-1:0]  pk, nk;
    logic signed [DATA_W-1:0] pd, nd;
    if (i == 0) begin : g_first
      assign pk = push_key;
      assign pd = push_data;
    end else begin : g_mid
      assign pk = cell_key[i-1];
      assign pd = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign nk = cell_key[0];
      assign nd = cell_data[0];
    end else begin : g_inner
      assign nk = cell_key[i+1];
      assign nd = cell_data[i+1];
    end
    uks_cell #(.IDX(i), .CW(CW)) u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .fill      (fill),
      .prev_key  (pk),
      .prev_data (pd),
      .next_key  (nk),
      .next_data (nd),
      .wrap_key  (cell_key[0]),
      .wrap_data (cell_data[0]),
      .key       (cell_key[i]),
      .data      (cell_data[i])
    );
  end

  assign out_tuser = out_status;
  assign out_tdata = {2'b00, out_empty, out_count, out_data, out_key};

endmodule

// ===== test/unique_key_stack_core_test.sv =====
// self-checking testbench of the unique key stack core with its own stack predictor
module unique_key_stack_core_test;
  import uks_pkg::*;

  localparam int STACK_DEPTH = DEPTH_DEF;
  localparam int HOLD_CYCLES = 80;

  typedef struct {
    status_t     status;
    logic [31:0] key;
    logic [31:0] data;
    logic [4:0]  count;
    logic        empty;
  } stack_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = CMD_QUERY;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [1:0]  out_tuser;
  logic [71:0] out_tdata;

  logic [31:0]   stack_keys [STACK_DEPTH];
  logic [31:0]   stack_data [STACK_DEPTH];
  int            stack_fill;
  stack_result_t pending_results [$];
  int            fail_count;
  bit            no_idle;
  int            hold_requests;
  int            hold_served;
  int            rx_stall;
  logic [31:0]   key_pool [24];

  unique_key_stack_core #(
    .DEPTH(STACK_DEPTH)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser(out_tuser),
    .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  function automatic stack_result_t stack_apply(cmd_t op, logic [31:0] key, logic [31:0] data);
    stack_result_t res;
    bit            found;
    found = 1'b0;
    res.status = ST_OK;
    res.key = '0;
    res.data = '0;
    case (op)
      CMD_PUSH: begin
        for (int i = 0; i < stack_fill; i++) begin
          if (stack_keys[i] == key) found = 1'b1;
        end
        if (found) begin
          res.status = ST_DUP;
        end else if (stack_fill >= STACK_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          stack_keys[stack_fill] = key;
          stack_data[stack_fill] = data;
          stack_fill++;
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (stack_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.key = stack_keys[stack_fill - 1];
          res.data = stack_data[stack_fill - 1];
          if (op == CMD_POP) stack_fill--;
        end
      end
      default: ;
    endcase
    res.count = stack_fill[4:0];
    res.empty = (stack_fill == 0);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
    fail_count++;
  endtask

  task automatic check_result();
    stack_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected result, key", '0, out_tdata[31:0]);
    end else begin
      want = pending_results.pop_front();
      if (out_tuser !== want.status)
        report_mismatch("status", 32'(want.status), 32'(out_tuser));
      if (out_tdata[31:0] !== want.key) report_mismatch("key", want.key, out_tdata[31:0]);
      if (out_tdata[63:32] !== want.data) report_mismatch("data", want.data, out_tdata[63:32]);
      if (out_tdata[68:64] !== want.count)
        report_mismatch("count", 32'(want.count), 32'(out_tdata[68:64]));
      if (out_tdata[69] !== want.empty)
        report_mismatch("empty", 32'(want.empty), 32'(out_tdata[69]));
    end
  endtask

  // result side: random stall per result, plus long hold-offs on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_result();
        rx_stall = no_idle ? 0 : $urandom_range(0, 6);
      end
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        rx_stall = HOLD_CYCLES;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_request(cmd_t op, logic [31:0] key, logic [31:0] data);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {data, key};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(stack_apply(op, key, data));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic cmd_t pick_cmd(int push_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) return CMD_PUSH;
    roll = $urandom_range(0, 9);
    if (roll < 6) return CMD_POP;
    if (roll < 9) return CMD_PEEK;
    return CMD_QUERY;
  endfunction

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 9) < 7) return key_pool[$urandom_range(0, 23)];
    return $urandom;
  endfunction

  task automatic test_empty_stack();
    send_request(CMD_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_PEEK, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(CMD_QUERY, 32'h0000_0000, 32'h0000_0000);
  endtask

  task automatic test_fill_to_full();
    logic [31:0] keys [16];
    keys = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
             32'h0000_0001, 32'h8000_0001, 32'h7FFF_FFFE, 32'hAAAA_AAAA,
             32'h5555_5555, 32'h1234_5678, 32'hEDCB_A987, 32'h0000_FFFF,
             32'hFFFF_0000, 32'h00FF_00FF, 32'hFF00_FF00, 32'h0F0F_0F0F};
    foreach (keys[i]) send_request(CMD_PUSH, keys[i], ~keys[i]);
    send_request(CMD_PUSH, 32'hF0F0_F0F0, 32'h1111_1111);
    send_request(CMD_PUSH, 32'h0000_0000, 32'h2222_2222);
    send_request(CMD_PEEK, 32'h0, 32'h0);
    send_request(CMD_POP, 32'h0, 32'h0);
    send_request(CMD_PUSH, 32'h5555_5555, 32'h3333_3333);
    send_request(CMD_PUSH, 32'h8000_0000, 32'h4444_4444);
    send_request(CMD_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_drained();
  endtask

  // alternating push-heavy and pop-heavy phases so the stack swings between empty and full
  task automatic test_random_mix(int count);
    int push_pct;
    int phase_left;
    cmd_t op;
    push_pct = 80;
    phase_left = 0;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < 24; i++) key_pool[i] = $urandom;
    for (int n = 0; n < count; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(10, 40);
        push_pct = (push_pct == 80) ? 25 : 80;
        no_idle = ($urandom_range(0, 4) == 0);
      end
      phase_left--;
      op = pick_cmd(push_pct);
      send_request(op, pick_key(), $urandom);
    end
    no_idle = 1'b0;
  endtask

  // result side held off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    wait_drained();
    no_idle = 1'b1;
    hold_requests++;
    for (int n = 0; n < 30; n++) send_request(pick_cmd(60), pick_key(), $urandom);
    no_idle = 1'b0;
  endtask

  task automatic test_drain_pause();
    for (int r = 0; r < 4; r++) begin
      wait_drained();
      for (int n = 0; n < 12; n++) send_request(pick_cmd(50), pick_key(), $urandom);
    end
  endtask

  initial begin
    fail_count = 0;
    stack_fill = 0;
    no_idle = 1'b0;
    hold_requests = 0;
    hold_served = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_stack();
    test_fill_to_full();
    test_random_mix(1200);
    test_backpressure();
    test_drain_pause();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (STACK_DEPTH + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("unique_key_stack_core_test passed");
    end else begin
      $display("unique_key_stack_core_test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("unique_key_stack_core_test failed");
    $finish;
  end

endmodule
